### hw/rtl/adc_sample_fifo_packetizer_macros.svh
// Assertion macros shared by the packetizer modules.
`ifndef ADC_SAMPLE_FIFO_PACKETIZER_MACROS_SVH
`define ADC_SAMPLE_FIFO_PACKETIZER_MACROS_SVH

// Same-cycle implication, checked on clk_i and switched off during reset.
`define ASFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("packetizer assertion failed");

// Next-cycle implication, checked on clk_i and switched off during reset.
`define ASFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("packetizer assertion failed");

`endif

### hw/rtl/asfp_pkg.sv
// Types, constants and sizes shared by the sample packetizer modules.
`default_nettype none
package asfp_pkg;

  localparam int RING_DEPTH     = 8192;
  localparam int PACKET_SAMPLES = 256;
  localparam int PTR_W          = $clog2(RING_DEPTH);
  localparam int PACKET_BYTES   = 4 + 2 * PACKET_SAMPLES;
  localparam int POS_W          = $clog2(PACKET_BYTES);
  localparam int CNT_W          = (PTR_W + 1 > 14) ? PTR_W + 1 : 14;
  localparam int SAMPLE_W       = 12;
  localparam int TAG_W          = 4;
  localparam int WORD_W         = 16;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  localparam logic             FUNC_PUSH  = 1'b0;
  localparam logic             FUNC_PULL  = 1'b1;
  localparam logic [TAG_W-1:0] CHAN_RESET = 4'd5;
  localparam logic [7:0]       SYNC_A     = 8'hAA;
  localparam logic [7:0]       SYNC_B     = 8'h55;
  localparam logic [7:0]       CNT_LO     = 8'(PACKET_SAMPLES & 255);
  localparam logic [7:0]       CNT_HI     = 8'((PACKET_SAMPLES >> 8) & 255);

  typedef enum logic [1:0] {
    KIND_CONST,
    KIND_LOW,
    KIND_HIGH
  } kind_e;

  typedef struct packed {
    logic                func;
    logic [WORD_W-1:0]   adc_word;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       packet_end;
    logic       sample_stored;
    logic       sample_dropped;
  } out_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] const_byte;
    logic       valid;
    logic       last;
    logic       stored;
    logic       dropped;
  } cmd_t;

  typedef struct packed {
    logic accept;
    cmd_t cmd;
  } issue_t;

endpackage
`default_nettype wire

### hw/rtl/asfp_ram.sv
// Sample ring storage: one write port and one registered read port.
`default_nettype none
module asfp_ram
  import asfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [PTR_W-1:0]    waddr_i,
  input  wire logic [SAMPLE_W-1:0] wdata_i,
  input  wire logic [PTR_W-1:0]    raddr_i,
  output logic      [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/asfp_front.sv
// Front end: accepts words, filters by channel, keeps ring pointers and packet position.
`default_nettype none
module asfp_front
  import asfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic                full_i,
  input  wire in_t                 in_i,
  input  wire logic                cfg_we_i,
  input  wire logic [TAG_W-1:0]    cfg_wdata_i,
  output issue_t                   issue_o,
  output logic                     ram_we_o,
  output logic      [PTR_W-1:0]    ram_waddr_o,
  output logic      [SAMPLE_W-1:0] ram_wdata_o,
  output logic      [PTR_W-1:0]    ram_raddr_o
);

  `include "adc_sample_fifo_packetizer_macros.svh"

  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d, wp_next, rp_next;
  logic [POS_W-1:0] pos_q, pos_d, pos;
  logic             active_q, active_d;
  logic [TAG_W-1:0] chan_q, chan_d;
  logic [CNT_W-1:0] count;
  logic             accept, ring_full, start;
  cmd_t             cmd;

  always_comb begin
    accept    = push_i && !full_i;
    wp_next   = (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    rp_next   = (rp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    if (wp_q >= rp_q) begin
      count = CNT_W'(wp_q) - CNT_W'(rp_q);
    end else begin
      count = CNT_W'(wp_q) + CNT_W'(RING_DEPTH) - CNT_W'(rp_q);
    end
    ring_full = (wp_next == rp_q);
    start     = !active_q && (count >= CNT_W'(PACKET_SAMPLES));
    pos       = active_q ? pos_q : '0;

    cmd       = '{kind: KIND_CONST, default: '0};
    wp_d      = wp_q;
    rp_d      = rp_q;
    pos_d     = pos_q;
    active_d  = active_q;
    chan_d    = cfg_we_i ? cfg_wdata_i : chan_q;
    ram_we_o  = 1'b0;

    if (accept) begin
      if (in_i.func == FUNC_PUSH) begin
        if (in_i.adc_word[WORD_W-1 -: TAG_W] == chan_q) begin
          if (ring_full) begin
            cmd.dropped = 1'b1;
          end else begin
            ram_we_o   = 1'b1;
            wp_d       = wp_next;
            cmd.stored = 1'b1;
          end
        end
      end else if (active_q || start) begin
        cmd.valid = 1'b1;
        case (pos)
          POS_W'(0): cmd.const_byte = SYNC_A;
          POS_W'(1): cmd.const_byte = SYNC_B;
          POS_W'(2): cmd.const_byte = CNT_LO;
          POS_W'(3): cmd.const_byte = CNT_HI;
          default: begin
            // Sample bytes alternate low then high; the slot is freed with the high byte.
            if (pos[0]) begin
              cmd.kind = KIND_HIGH;
              rp_d     = rp_next;
            end else begin
              cmd.kind = KIND_LOW;
            end
          end
        endcase
        if (pos == POS_W'(PACKET_BYTES - 1)) begin
          cmd.last = 1'b1;
          active_d = 1'b0;
          pos_d    = '0;
        end else begin
          active_d = 1'b1;
          pos_d    = pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      pos_q    <= '0;
      active_q <= 1'b0;
      chan_q   <= CHAN_RESET;
    end else begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      pos_q    <= pos_d;
      active_q <= active_d;
      chan_q   <= chan_d;
    end
  end

  assign issue_o     = '{accept: accept, cmd: cmd};
  assign ram_waddr_o = wp_q;
  assign ram_wdata_o = in_i.adc_word[SAMPLE_W-1:0];
  assign ram_raddr_o = rp_q;

  `ASFP_ASSERT_IMPL(a_idle_pos, !active_q, pos_q == '0)
  `ASFP_ASSERT_NEXT(a_release, accept && cmd.kind == KIND_HIGH, rp_q != $past(rp_q))

endmodule
`default_nettype wire

### hw/rtl/asfp_back.sv
// Back end: joins commands with ring data and queues finished result words.
`default_nettype none
module asfp_back
  import asfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire issue_t              issue_i,
  input  wire logic [SAMPLE_W-1:0] rdata_i,
  input  wire logic                pop_i,
  output logic                     full_o,
  output logic                     empty_o,
  output out_t                     out_o
);

  `include "adc_sample_fifo_packetizer_macros.svh"

  logic              s1_valid_q;
  cmd_t              s1_cmd_q;
  out_t              res;
  out_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [QCNT_W:0]   in_flight;
  logic              pop_ok;

  always_comb begin
    res.byte_valid     = s1_cmd_q.valid;
    res.packet_end     = s1_cmd_q.last;
    res.sample_stored  = s1_cmd_q.stored;
    res.sample_dropped = s1_cmd_q.dropped;
    case (s1_cmd_q.kind)
      KIND_CONST: res.out_byte = s1_cmd_q.const_byte;
      KIND_LOW:   res.out_byte = rdata_i[7:0];
      KIND_HIGH:  res.out_byte = 8'(rdata_i[SAMPLE_W-1:8]);
      default:    res.out_byte = '0;
    endcase
  end

  // The command stage always drains next cycle, so it counts against queue space.
  assign in_flight = (QCNT_W+1)'(cnt_q) + (QCNT_W+1)'(s1_valid_q);
  assign full_o    = in_flight >= (QCNT_W+1)'(QDEPTH);
  assign empty_o   = (cnt_q == '0);
  assign pop_ok    = pop_i && !empty_o;
  assign out_o     = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (s1_valid_q) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCNT_W'(s1_valid_q) - QCNT_W'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= issue_i.accept;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q <= issue_i.cmd;
    if (s1_valid_q) begin
      q_mem[wr_ptr_q] <= res;
    end
  end

  `ASFP_ASSERT_IMPL(a_room, s1_valid_q, cnt_q < QCNT_W'(QDEPTH))
  `ASFP_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH))

endmodule
`default_nettype wire

### hw/rtl/adc_sample_fifo_packetizer.sv
// Converter sample filter, sample ring and serial packet builder: top level.
//
// Input words enter on push/full with in_i: func 0 pushes a converter word,
// func 1 asks for one packet byte. One result word per input word leaves on
// empty/pop with out_o, in input order. A packet is 0xAA, 0x55, the sample
// count low and high bytes, then every sample as low byte and high byte; it
// starts only once the ring holds a whole packet of samples.
// Throughput is one word per cycle on both sides while full does not hold the input
// and empty does not hold the output. The front updates the ring pointers and issues
// the ring read at acceptance, the back joins the registered ring data in the next
// cycle and writes the result queue, whose head is on out_o the cycle after.
// The result queue holds four words. full rises when the queued words plus
// the one in the join stage reach four, so a stalled receiver holds the input
// after at most four words and no word is lost.
// The channel register is written through cfg_we_i and cfg_wdata_i with no
// wait. Reset clears both ring pointers, ends any packet, empties the queue
// and sets the channel to 5; the ring storage itself is not cleared.
`default_nettype none
module adc_sample_fifo_packetizer
  import asfp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire in_t              in_i,
  output logic                  empty,
  input  wire logic             pop,
  output out_t                  out_o,
  input  wire logic             cfg_we_i,
  input  wire logic [TAG_W-1:0] cfg_wdata_i
);

  issue_t              issue;
  logic                ram_we;
  logic [PTR_W-1:0]    ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  asfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .issue_o     (issue),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr)
  );

  asfp_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  asfp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .rdata_i (ram_rdata),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

### tb/adc_packet_checker.sv
// Result checker for the sample packetizer: predicts every result word and compares it.
module adc_packet_checker
  import asfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  logic             full,
  input  in_t              in_i,
  input  logic             empty,
  input  logic             pop,
  input  out_t             out_i,
  input  logic             cfg_we_i,
  input  logic [TAG_W-1:0] cfg_wdata_i,
  output int               errors_o,
  output int               pending_o
);

  localparam int   MAX_REPORTS = 10;

  logic [SAMPLE_W-1:0] samples [RING_DEPTH];
  int                  wr_idx;
  int                  rd_idx;
  int                  byte_idx;
  logic                in_packet;
  logic [TAG_W-1:0]    channel;
  out_t                awaited[$];
  int                  fail_count;
  int                  words_seen;

  function automatic out_t packet_response(input in_t w);
    out_t                r;
    int                  nxt;
    int                  fill;
    kind_e               kind;
    logic [SAMPLE_W-1:0] v;
    r = '0;
    if (w.func == FUNC_PUSH) begin
      if (w.adc_word[WORD_W-1 -: TAG_W] == channel) begin
        nxt = (wr_idx + 1) % RING_DEPTH;
        // One slot is always kept free, so a full ring loses the sample.
        if (nxt == rd_idx) begin
          r.sample_dropped = 1'b1;
        end else begin
          samples[wr_idx] = w.adc_word[SAMPLE_W-1:0];
          wr_idx = nxt;
          r.sample_stored = 1'b1;
        end
      end
    end else begin
      fill = (wr_idx - rd_idx + RING_DEPTH) % RING_DEPTH;
      if (!in_packet && fill >= PACKET_SAMPLES) begin
        in_packet = 1'b1;
        byte_idx = 0;
      end
      if (in_packet) begin
        v = samples[rd_idx];
        if (byte_idx < 4) kind = KIND_CONST;
        else if (((byte_idx - 4) % 2) == 0) kind = KIND_LOW;
        else kind = KIND_HIGH;
        r.byte_valid = 1'b1;
        case (kind)
          KIND_CONST: begin
            case (byte_idx)
              0:       r.out_byte = SYNC_A;
              1:       r.out_byte = SYNC_B;
              2:       r.out_byte = CNT_LO;
              default: r.out_byte = CNT_HI;
            endcase
          end
          KIND_LOW: r.out_byte = v[7:0];
          default: begin
            // The slot is released once its high byte has gone out.
            r.out_byte = 8'(v[SAMPLE_W-1:8]);
            rd_idx = (rd_idx + 1) % RING_DEPTH;
          end
        endcase
        if (byte_idx + 1 >= PACKET_BYTES) begin
          r.packet_end = 1'b1;
          in_packet = 1'b0;
          byte_idx = 0;
        end else begin
          byte_idx++;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      wr_idx = 0;
      rd_idx = 0;
      byte_idx = 0;
      in_packet = 1'b0;
      channel = CHAN_RESET;
      awaited.delete();
      fail_count = 0;
      words_seen = 0;
    end else begin
      if (pop && !empty) begin
        words_seen++;
        if (awaited.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("word %0d arrived with nothing outstanding: byte %h valid %b ",
                     words_seen, out_i.out_byte, out_i.byte_valid,
                     "end %b stored %b dropped %b", out_i.packet_end,
                     out_i.sample_stored, out_i.sample_dropped);
        end else begin
          want = awaited.pop_front();
          if (out_i.out_byte !== want.out_byte || out_i.byte_valid !== want.byte_valid ||
              out_i.packet_end !== want.packet_end ||
              out_i.sample_stored !== want.sample_stored ||
              out_i.sample_dropped !== want.sample_dropped) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("word %0d mismatch: expected byte %h valid %b end %b ", words_seen,
                       want.out_byte, want.byte_valid, want.packet_end,
                       "stored %b dropped %b, got byte %h valid %b end %b ",
                       want.sample_stored, want.sample_dropped, out_i.out_byte,
                       out_i.byte_valid, out_i.packet_end, "stored %b dropped %b",
                       out_i.sample_stored, out_i.sample_dropped);
          end
        end
      end
      if (cfg_we_i) channel = cfg_wdata_i;
      if (push && !full) awaited.push_back(packet_response(in_i));
    end
    errors_o <= fail_count;
    pending_o <= awaited.size();
  end

endmodule

### tb/adc_sample_fifo_packetizer_tb.sv
// Testbench top for the sample packetizer: stimulus, handshake pacing and verdict.
module adc_sample_fifo_packetizer_tb
  import asfp_pkg::*;
();

  localparam int   CYCLE_LIMIT = 50000;
  localparam int   LONG_HOLD   = 300;
  localparam int   PHASE_WORDS = 70;
  localparam int   FILL_WORDS  = 80;
  localparam int   DRAIN_WORDS = 60;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             push      = 1'b0;
  logic             pop       = 1'b0;
  in_t              in_d      = '0;
  logic             cfg_we    = 1'b0;
  logic [TAG_W-1:0] cfg_wdata = '0;
  logic             full;
  logic             empty;
  out_t             out_w;
  int               errors;
  int               pending;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int cycles       = 0;

  int phase_chan [4] = '{15, 0, 10, 5};
  int phase_idle [4] = '{0, 61, 0, 25};
  int phase_stall[4] = '{0, 0, 61, 25};

  adc_sample_fifo_packetizer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_d),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_w),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  adc_packet_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_d),
    .empty       (empty),
    .pop         (pop),
    .out_i       (out_w),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("adc_sample_fifo_packetizer_tb: errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        holds_served++;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input logic f, input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_d <= {f, w};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Stop offering words until every result word has been taken.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_channel(input logic [TAG_W-1:0] ch);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= ch;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n_words, input logic [TAG_W-1:0] ch);
    int done;
    int burst;
    int j;
    done = 0;
    while (done < n_words) begin
      if ($urandom_range(99) < 75) begin
        // A run of samples, mostly on the selected channel, then a few byte requests.
        burst = $urandom_range(24, 1);
        if (burst > n_words - done) burst = n_words - done;
        for (j = 0; j < burst; j++) begin
          if ($urandom_range(99) < 8) send_word(FUNC_PUSH, 16'($urandom));
          else send_word(FUNC_PUSH, {ch, 12'($urandom)});
        end
        done += burst;
        burst = $urandom_range(4, 1);
        if (burst > n_words - done) burst = n_words - done;
        for (j = 0; j < burst; j++) send_word(FUNC_PULL, 16'($urandom));
        done += burst;
      end else begin
        send_word(1'($urandom), 16'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    int p;
    int j;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset channel: requests with too few samples, value extremes, foreign tags.
    send_word(FUNC_PULL, 16'h0000);
    send_word(FUNC_PUSH, 16'h5000);
    send_word(FUNC_PUSH, 16'h5FFF);
    send_word(FUNC_PUSH, 16'h5A5A);
    send_word(FUNC_PUSH, 16'h0000);
    send_word(FUNC_PUSH, 16'hFFFF);
    send_word(FUNC_PUSH, 16'h4FFF);
    send_word(FUNC_PUSH, 16'h6000);
    send_word(FUNC_PULL, 16'hFFFF);
    set_channel(4'hF);
    send_word(FUNC_PUSH, 16'hFFFF);
    send_word(FUNC_PUSH, 16'hF000);
    send_word(FUNC_PUSH, 16'h5123);
    set_channel(4'h0);
    send_word(FUNC_PUSH, 16'h0000);
    send_word(FUNC_PUSH, 16'h0FFF);
    send_word(FUNC_PUSH, 16'h1000);
    send_word(FUNC_PULL, 16'h0000);

    for (p = 0; p < 4; p++) begin
      set_channel(4'(phase_chan[p]));
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      random_phase(PHASE_WORDS, 4'(phase_chan[p]));
    end

    // Keep offering samples while the receiver holds off, so the result queue
    // fills up and the input stalls.
    set_channel(4'h3);
    idle_pct = 0;
    stall_pct = 0;
    holds_asked++;
    for (j = 0; j < FILL_WORDS; j++) send_word(FUNC_PUSH, {4'h3, 12'($urandom)});
    settle();

    // Mostly byte requests, with the odd sample arriving in between.
    idle_pct = 25;
    stall_pct = 25;
    for (j = 0; j < DRAIN_WORDS; j++) begin
      if ($urandom_range(99) < 20) send_word(FUNC_PUSH, {4'h3, 12'($urandom)});
      else send_word(FUNC_PULL, 16'($urandom));
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("adc_sample_fifo_packetizer_tb: clean");
    else $display("adc_sample_fifo_packetizer_tb: errors");
    $finish;
  end

endmodule
